// File: sv/overwrite_ring_buffer_top_defines.svh
// assertion macros for the overwrite ring buffer
// expects clk_i and rst_ni in the scope of each use
`ifndef OVERWRITE_RING_BUFFER_TOP_DEFINES_SVH
`define OVERWRITE_RING_BUFFER_TOP_DEFINES_SVH

// property checked at every edge outside reset
`define ORB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ORB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/orb_pkg.sv
// shared types and codes for the overwrite ring buffer
// no dependencies
package orb_pkg;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [1:0] STATUS_OVERWRITE = 2'd2;

  localparam int RESET_CAPACITY = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

// File: sv/orb_req_if.sv
// request channel: push or pop with data
// no dependencies
interface orb_req_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [DATA_WIDTH-1:0] data_in;

  modport source (output valid, req_type, data_in, input ready);
  modport sink (input valid, req_type, data_in, output ready);
endinterface

// File: sv/orb_rsp_if.sv
// result channel: popped value, status and ring occupancy
// no dependencies
interface orb_rsp_if #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5
) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] pop_value;
  logic [1:0]            status;
  logic [CNT_W-1:0]      occupancy;
  logic                  is_full;
  logic                  is_empty;
  logic [DATA_WIDTH-1:0] oldest_value;

  modport source (output valid, pop_value, status, occupancy, is_full, is_empty, oldest_value,
                  input ready);
  modport sink (input valid, pop_value, status, occupancy, is_full, is_empty, oldest_value,
                output ready);
endinterface

// File: sv/overwrite_ring_buffer_top.sv
// top level of the overwrite ring buffer: controller plus datapath
// depends on orb_pkg, orb_req_if, orb_rsp_if, orb_ctrl and orb_dp
//
//   channel   direction  handshake            payload
//   in_if     in         valid / ready        req_type, data_in
//   rsp_if    out        valid / ready        pop_value, status, occupancy, flags, oldest_value
//   cfg       in         cfg_we_i             cfg_wdata_i (capacity in use)
//
// an item goes in order through capture, pointer update and memory write, head read, result load
// a new item is taken only after the last one has loaded its result; one registered read port at the head
// reset clears pointers and count and sets capacity to the smaller of DEPTH and 16; no memory clearing pass
// a stalled result holds in the output register; the next item is taken meanwhile and
// waits in its last step until that register frees
module overwrite_ring_buffer_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [$clog2(DEPTH+1)-1:0]      cfg_wdata_i,
  orb_req_if.sink                         in_if,
  orb_rsp_if.source                       rsp_if
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  orb_pkg::dp_cmd_t cmd;
  orb_pkg::dp_sts_t sts;

  orb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  orb_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (in_if.req_type),
    .data_in_i      (in_if.data_in),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (rsp_if.valid),
    .out_ready_i    (rsp_if.ready),
    .pop_value_o    (rsp_if.pop_value),
    .status_o       (rsp_if.status),
    .occupancy_o    (rsp_if.occupancy),
    .is_full_o      (rsp_if.is_full),
    .is_empty_o     (rsp_if.is_empty),
    .oldest_value_o (rsp_if.oldest_value)
  );

endmodule

// File: sv/orb_ctrl.sv
// sequencing state machine for the overwrite ring buffer
// depends on orb_pkg
module orb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  orb_pkg::dp_sts_t   sts_i,
  output orb_pkg::dp_cmd_t   cmd_o
);

  orb_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= orb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      orb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = orb_pkg::ST_EXEC;
        end
      end
      orb_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = orb_pkg::ST_READ;
      end
      orb_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = orb_pkg::ST_FIN;
      end
      orb_pkg::ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d    = orb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = orb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/orb_dp.sv
// pointers, count, entry memory and result register of the ring buffer
// depends on orb_pkg and overwrite_ring_buffer_top_defines.svh
`include "overwrite_ring_buffer_top_defines.svh"

module orb_dp #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i,
  input  logic                  req_type_i,
  input  logic [DATA_WIDTH-1:0] data_in_i,
  input  orb_pkg::dp_cmd_t      cmd_i,
  output orb_pkg::dp_sts_t      sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] pop_value_o,
  output logic [1:0]            status_o,
  output logic [CNT_W-1:0]      occupancy_o,
  output logic                  is_full_o,
  output logic                  is_empty_o,
  output logic [DATA_WIDTH-1:0] oldest_value_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CapReset = (DEPTH < orb_pkg::RESET_CAPACITY) ? DEPTH
                                                              : orb_pkg::RESET_CAPACITY;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx,
                                              input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(idx) + CNT_W'(1);
    return (n >= cap) ? '0 : AW'(n);
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;

  logic                  req_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [AW-1:0]         head_q, head_d;
  logic [AW-1:0]         tail_q, tail_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      cap_q, cap_d;
  logic                  pop_ok_q, pop_ok_d;
  logic [1:0]            stat_q, stat_d;
  logic [DATA_WIDTH-1:0] popped_q;

  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_pop_q;
  logic [1:0]            out_stat_q;
  logic [CNT_W-1:0]      out_occ_q;
  logic                  out_full_q;
  logic                  out_empty_q;
  logic [DATA_WIDTH-1:0] out_oldest_q;

  // capacity clamp on write
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_d = CNT_W'(1);
    end else if (cfg_wdata_i > CNT_W'(DEPTH)) begin
      cap_d = CNT_W'(DEPTH);
    end else begin
      cap_d = cfg_wdata_i;
    end
  end

  // pointer and count update for one item
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    pop_ok_d = 1'b0;
    stat_d   = orb_pkg::STATUS_OK;
    if (req_q == orb_pkg::REQ_PUSH) begin
      tail_d = ring_next(tail_q, cap_q);
      if (count_q < cap_q) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        head_d = ring_next(head_q, cap_q);
        stat_d = orb_pkg::STATUS_OVERWRITE;
      end
    end else if (count_q == '0) begin
      stat_d = orb_pkg::STATUS_UNDERFLOW;
    end else begin
      head_d   = ring_next(head_q, cap_q);
      count_d  = count_q - CNT_W'(1);
      pop_ok_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      cap_q   <= CNT_W'(CapReset);
    end else if (cfg_we_i) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      cap_q   <= cap_d;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // single write port at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (req_q == orb_pkg::REQ_PUSH)) begin
      mem[tail_q] <= data_q;
    end
    rd_q <= mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      data_q <= data_in_i;
    end
    if (cmd_i.exec) begin
      pop_ok_q <= pop_ok_d;
      stat_q   <= stat_d;
    end
    if (cmd_i.read) begin
      popped_q <= pop_ok_q ? rd_q : '0;
    end
    if (cmd_i.load) begin
      out_pop_q    <= popped_q;
      out_stat_q   <= stat_q;
      out_occ_q    <= count_q;
      out_full_q   <= (count_q == cap_q);
      out_empty_q  <= (count_q == '0);
      out_oldest_q <= (count_q != '0) ? rd_q : '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign pop_value_o    = out_pop_q;
  assign status_o       = out_stat_q;
  assign occupancy_o    = out_occ_q;
  assign is_full_o      = out_full_q;
  assign is_empty_o     = out_empty_q;
  assign oldest_value_o = out_oldest_q;

  `ORB_ASSERT(a_count_in_range, count_q <= cap_q, "entry count above capacity")
  `ORB_ASSERT(a_ptr_in_range, (CNT_W'(head_q) < cap_q) && (CNT_W'(tail_q) < cap_q), "pointer beyond capacity")
  `ORB_ASSERT(a_ring_aligned, ((count_q == '0) || (count_q == cap_q)) |-> (head_q == tail_q), "head and tail disagree with count")
  `ORB_ASSERT_NEXT(a_load_sets_valid, cmd_i.load, out_valid_q, "loaded result not presented")

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// testbench for overwrite_ring_buffer_top: push and pop items with random idling on both
// channels and a long result stall, every result checked against a ring model kept here
// depends on orb_pkg, orb_req_if, orb_rsp_if and overwrite_ring_buffer_top
module tb_top;

  localparam int DEPTH         = 16;
  localparam int DATA_WIDTH    = 32;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_STALL    = 60;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] pop_value;
    logic [1:0]            status;
    logic [CNT_W-1:0]      occupancy;
    logic                  is_full;
    logic                  is_empty;
    logic [DATA_WIDTH-1:0] oldest_value;
  } ring_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  orb_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
  orb_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .CNT_W(CNT_W)) rsp_ch ();

  overwrite_ring_buffer_top #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (req_ch),
    .rsp_if     (rsp_ch)
  );

  logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
  int unsigned           ring_head;
  int unsigned           ring_tail;
  int unsigned           ring_count;
  logic [CNT_W-1:0]      capacity_reg;
  ring_result_t          pending_results [$];
  int unsigned           mismatches = 0;
  int unsigned           cycle_count = 0;
  bit                    sender_idle_en;
  bit                    rsp_idle_en;
  bit                    rsp_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // capacity 0 behaves as 1, anything above the depth as the depth
  function automatic int unsigned live_capacity();
    if (capacity_reg == '0) return 1;
    if (capacity_reg > DEPTH) return DEPTH;
    return capacity_reg;
  endfunction

  function automatic int unsigned ring_advance(int unsigned idx);
    return (idx + 1 >= live_capacity()) ? 0 : idx + 1;
  endfunction

  function automatic ring_result_t predict_ring_result(logic req, logic [DATA_WIDTH-1:0] data);
    ring_result_t r;
    int unsigned  cap;
    cap = live_capacity();
    r = '0;
    if (req == orb_pkg::REQ_PUSH) begin
      ring_mem[ring_tail] = data;
      ring_tail = ring_advance(ring_tail);
      if (ring_count < cap) begin
        ring_count++;
      end else begin
        ring_head = ring_advance(ring_head);
        r.status = orb_pkg::STATUS_OVERWRITE;
      end
    end else if (ring_count == 0) begin
      r.status = orb_pkg::STATUS_UNDERFLOW;
    end else begin
      r.pop_value = ring_mem[ring_head];
      ring_head = ring_advance(ring_head);
      ring_count--;
    end
    r.occupancy = CNT_W'(ring_count);
    r.is_full = (ring_count == cap);
    r.is_empty = (ring_count == 0);
    if (ring_count != 0) r.oldest_value = ring_mem[ring_head];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [DATA_WIDTH-1:0] want,
                                        logic [DATA_WIDTH-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  task automatic check_result();
    ring_result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      $display("%0t: result with no item outstanding, expected none actual status %0h",
               $time, rsp_ch.status);
      return;
    end
    want = pending_results.pop_front();
    compare_field("pop_value", want.pop_value, rsp_ch.pop_value);
    compare_field("status", want.status, rsp_ch.status);
    compare_field("occupancy", want.occupancy, rsp_ch.occupancy);
    compare_field("is_full", want.is_full, rsp_ch.is_full);
    compare_field("is_empty", want.is_empty, rsp_ch.is_empty);
    compare_field("oldest_value", want.oldest_value, rsp_ch.oldest_value);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_result();
  end

  // result side: random short stalls, or one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk_i);
        rsp_hold_req = 1'b0;
      end else if (rsp_idle_en && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic req, logic [DATA_WIDTH-1:0] data);
    int unsigned  gap;
    ring_result_t expected;
    @(negedge clk_i);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= req;
    req_ch.data_in  <= data;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    expected = predict_ring_result(req, data);
    pending_results = {pending_results, expected};
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // a capacity write also empties the ring
  task automatic write_capacity(logic [CNT_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    capacity_reg = value;
    ring_head    = 0;
    ring_tail    = 0;
    ring_count   = 0;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int unsigned n_items, int unsigned push_pct);
    repeat (n_items) begin
      send_item(($urandom_range(0, 99) < push_pct) ? orb_pkg::REQ_PUSH : orb_pkg::REQ_POP,
                $urandom);
    end
  endtask

  // reset capacity: underflow, data extremes, fill to full, then overwrite the oldest
  task automatic test_directed();
    send_item(orb_pkg::REQ_POP, 32'hFFFF_FFFF);
    send_item(orb_pkg::REQ_PUSH, 32'h0000_0000);
    send_item(orb_pkg::REQ_PUSH, 32'hFFFF_FFFF);
    send_item(orb_pkg::REQ_POP, 32'h0000_0000);
    send_item(orb_pkg::REQ_POP, 32'h0000_0000);
    send_item(orb_pkg::REQ_POP, 32'h0000_0000);
    for (int i = 0; i < DEPTH; i++) begin
      send_item(orb_pkg::REQ_PUSH, (i % 2 == 0) ? (32'h1 << i) : ~(32'h1 << i));
    end
    send_item(orb_pkg::REQ_PUSH, 32'hA5A5_A5A5);
    send_item(orb_pkg::REQ_PUSH, 32'h5A5A_5A5A);
  endtask

  // smallest, zero, above depth, full depth, two and a random mid-range capacity
  task automatic test_capacity_sweep();
    logic [CNT_W-1:0] caps [7];
    caps = '{CNT_W'(1), CNT_W'(0), CNT_W'(31), CNT_W'(17), CNT_W'(16), CNT_W'(2),
             CNT_W'($urandom_range(3, 15))};
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      run_random(35, (caps[i] >= 16) ? 70 : 60);
    end
  endtask

  // results held back long enough that the block stalls its input
  task automatic test_backpressure();
    write_capacity(CNT_W'(8));
    sender_idle_en = 1'b0;
    rsp_hold_req   = 1'b1;
    run_random(30, 60);
    sender_idle_en = 1'b1;
  endtask

  task automatic test_random_mix();
    int unsigned bias [3];
    bias = '{30, 50, 75};
    for (int p = 0; p < 10; p++) begin
      write_capacity(CNT_W'($urandom_range(0, 31)));
      run_random(40, bias[p % 3]);
    end
  endtask

  task automatic test_full_rate();
    sender_idle_en = 1'b0;
    rsp_idle_en    = 1'b0;
    write_capacity(CNT_W'($urandom_range(1, 16)));
    run_random(80, 55);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = orb_pkg::REQ_PUSH;
    req_ch.data_in  = '0;
    sender_idle_en  = 1'b1;
    rsp_idle_en     = 1'b1;
    rsp_hold_req    = 1'b0;
    capacity_reg    = CNT_W'(orb_pkg::RESET_CAPACITY);
    ring_head       = 0;
    ring_tail       = 0;
    ring_count      = 0;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_capacity_sweep();
    test_backpressure();
    test_random_mix();
    test_full_rate();

    drain_results();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/orb_pkg.sv
sv/orb_req_if.sv
sv/orb_rsp_if.sv
sv/orb_ctrl.sv
sv/orb_dp.sv
sv/overwrite_ring_buffer_top.sv
tb/sv/tb_top.sv
